// ===== hdl/multiwave_sample_generator_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the multiwave sample generator
// Shared property wrappers, clocked on the rising edge, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef MULTIWAVE_SAMPLE_GENERATOR_CORE_MACROS_SVH
`define MULTIWAVE_SAMPLE_GENERATOR_CORE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define MWSG_ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MWSG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mwsg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwsg_pkg
// Types, codes, fixed-point constants and the quarter-wave sine function.
// ---------------------------------------------------------------------------
package mwsg_pkg;

    localparam int SINE_TABLE_DEPTH_DEFAULT = 256;
    localparam int PHASE_BITS_DEFAULT       = 32;
    localparam int QUEUE_DEPTH              = 4;

    localparam int WAVE_W      = 3;
    localparam int AMP_W       = 24;
    localparam int PCT_W       = 21;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SAMPLE_W    = 32;
    localparam int PHASE_OUT_W = 32;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = SAMPLE_W + PHASE_OUT_W;

    localparam int PEAK_W      = 25;                 // sqrt2 / sqrt3 scaled peak
    localparam int PEAK_PROD_W = 41;                 // amplitude times Q16 factor
    localparam int BIAS_W      = 32;
    localparam int PROD_D_W    = AMP_W + PCT_W;      // amplitude times percent magnitude
    localparam int REM_W       = 14;
    localparam int TAB_W       = 15;                 // Q0.15 magnitude

    // divide by 10000 as long division in 16-bit digits
    localparam int DIV_DIGIT_W = 16;
    localparam int DIV_DIGITS  = 3;
    localparam int DIVIDEND_W  = DIV_DIGIT_W * DIV_DIGITS;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 44;

    localparam logic [16:0]         SQRT2_Q16    = 17'd92682;
    localparam logic [16:0]         SQRT3_Q16    = 17'd113512;
    localparam logic [REM_W-1:0]    BIAS_DIVISOR = 14'd10000;
    localparam logic [12:0]         BIAS_ROUND   = 13'd5000;
    localparam logic [63:0]         HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0]         FULL_Q15     = 64'd32767;
    // ceil(2^44 / 10000), exact for any 30-bit partial dividend
    localparam logic [RECIP_W-1:0]  RECIP_10000  = 31'd1759218605;

    localparam logic [63:0] TAYLOR_DIV [10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_TRIANGLE = 3'd2,
        WAVE_DC       = 3'd3
    } wave_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVE_TYPE      = 3'd0,
        CFG_AMPLITUDE_RMS  = 3'd1,
        CFG_PHASE_OFFSET   = 3'd2,
        CFG_OFFSET_PERCENT = 3'd3,
        CFG_PHASE_STEP     = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        COEF_IDLE,
        COEF_MUL,
        COEF_DIV,
        COEF_REM
    } coef_state_t;

    typedef struct packed {
        logic [PEAK_W-1:0]        sine_peak;
        logic [PEAK_W-1:0]        tri_peak;
        logic signed [BIAS_W-1:0] bias;
    } coef_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // 32767 * sin(ang), ang in Q30 radians, eleven-term Taylor series, rounded.
    function automatic logic [TAB_W-1:0] quarter_sine_q15(input logic [63:0] ang);
        logic [63:0]        sq;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        e;
        int                 t;
        sq   = (ang * ang) >> 30;
        term = ang;
        acc  = signed'(ang);
        for (t = 1; t <= 10; t++) begin
            term = (term * sq) >> 30;
            term = term / TAYLOR_DIV[t-1];
            if ((t & 1) != 0) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        if (acc < 0) begin
            acc = 64'sd0;
        end
        e = ((unsigned'(acc) * FULL_Q15) + (64'd1 << 29)) >> 30;
        if (e > FULL_Q15) begin
            e = FULL_Q15;
        end
        return e[TAB_W-1:0];
    endfunction

endpackage

// ===== hdl/multiwave_sample_generator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multiwave_sample_generator_core
// DDS sample generator: sine, square, triangle and DC in milli-units.
// ---------------------------------------------------------------------------
// One sample per clock: every accepted tick word gives one result word, and
// a new tick is taken each cycle while the four-entry phase queue has room
// and no coefficient update is running. A result passes the queue, then the
// registered stages for table index, table read, multiply and rounding, then
// the bias add with saturation into the output register. After reset and
// after every configuration write the input is held off while the peak and
// bias coefficients are recomputed; the bias takes a multiply state, then the
// divide by 10000 in three 16-bit quotient digits, each a divide and a remainder state.
// Configuration registers: 0 wave select, 1 amplitude_rms, 2 phase_offset,
// 3 offset_percent, 4 phase_step; other indexes are ignored.
// ---------------------------------------------------------------------------
`include "multiwave_sample_generator_core_macros.svh"

module multiwave_sample_generator_core #(
    parameter int SINE_TABLE_DEPTH = mwsg_pkg::SINE_TABLE_DEPTH_DEFAULT,
    parameter int PHASE_BITS       = mwsg_pkg::PHASE_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mwsg_pkg::S_TDATA_W-1:0]   s_tdata,    // [0] restart
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mwsg_pkg::M_TDATA_W-1:0]   m_tdata,    // [31:0] sample_value, [63:32] phase_now
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mwsg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mwsg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mwsg_pkg::*;

    logic [WAVE_W-1:0]       wave_sel_reg;
    logic [AMP_W-1:0]        amplitude_rms_reg;
    logic [PHASE_BITS-1:0]   phase_offset_reg;
    logic signed [PCT_W-1:0] offset_percent_reg;
    logic [PHASE_BITS-1:0]   phase_step_reg;

    logic                    cfg_write;
    logic                    coef_busy;
    coef_t                   coef;
    q_status_t               q_status;
    logic                    q_push;
    logic                    q_pop;
    logic [PHASE_BITS-1:0]   q_push_data;
    logic [PHASE_BITS-1:0]   q_pop_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_sel_reg       <= WAVE_SINE;
            amplitude_rms_reg  <= AMP_W'(57700);
            phase_offset_reg   <= '0;
            offset_percent_reg <= '0;
            phase_step_reg     <= PHASE_BITS'(32'd21474836);
        end else if (cfg_write) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WAVE_TYPE:      wave_sel_reg       <= cfg_data[WAVE_W-1:0];
                CFG_AMPLITUDE_RMS:  amplitude_rms_reg  <= cfg_data[AMP_W-1:0];
                CFG_PHASE_OFFSET:   phase_offset_reg   <= cfg_data[PHASE_BITS-1:0];
                CFG_OFFSET_PERCENT: offset_percent_reg <= signed'(cfg_data[PCT_W-1:0]);
                CFG_PHASE_STEP:     phase_step_reg     <= cfg_data[PHASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    mwsg_coef u_coef (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (cfg_write),
        .amplitude      (amplitude_rms_reg),
        .offset_percent (offset_percent_reg),
        .coef           (coef),
        .busy           (coef_busy)
    );

    mwsg_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .phase_offset (phase_offset_reg),
        .phase_step   (phase_step_reg),
        .hold         (coef_busy),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    mwsg_fifo #(
        .WIDTH (PHASE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    mwsg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .wave_sel  (wave_sel_reg),
        .amplitude (amplitude_rms_reg),
        .coef      (coef),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `MWSG_ASSERT_ALWAYS(a_hold_while_busy, aclk, aresetn, coef_busy |-> !s_tready, "tick taken during coefficient update")
    `MWSG_ASSERT_NEXT(a_cfg_recompute, aclk, aresetn, cfg_write, coef_busy, "configuration write did not restart coefficients")
    `MWSG_ASSERT_NEXT(a_tick_queued, aclk, aresetn, s_tvalid && s_tready, !q_status.empty, "accepted tick missing from queue")

endmodule

// ===== hdl/mwsg_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwsg_fifo
// Short show-ahead queue of phase words between front and back.
// ---------------------------------------------------------------------------
`include "multiwave_sample_generator_core_macros.svh"

module mwsg_fifo #(
    parameter int WIDTH = mwsg_pkg::PHASE_BITS_DEFAULT,
    parameter int DEPTH = mwsg_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      pop_data,
    output mwsg_pkg::q_status_t   status
);
    import mwsg_pkg::*;

    localparam int AddrW  = $clog2(DEPTH);
    localparam int CountW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [AddrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CountW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `MWSG_ASSERT_ALWAYS(a_no_push_full, aclk, aresetn, push |-> !status.full, "push into full queue")
    `MWSG_ASSERT_ALWAYS(a_no_pop_empty, aclk, aresetn, pop |-> !status.empty, "pop from empty queue")
    `MWSG_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CountW'(DEPTH), "queue count overrun")

endmodule

// ===== hdl/mwsg_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwsg_front
// Accepts tick words, runs the phase accumulator and queues the tick phase.
// ---------------------------------------------------------------------------
module mwsg_front #(
    parameter int PHASE_BITS = mwsg_pkg::PHASE_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mwsg_pkg::S_TDATA_W-1:0] s_tdata,    // [0] restart
    input  logic [PHASE_BITS-1:0]          phase_offset,
    input  logic [PHASE_BITS-1:0]          phase_step,
    input  logic                           hold,
    input  mwsg_pkg::q_status_t            q_status,
    output logic                           q_push,
    output logic [PHASE_BITS-1:0]          q_data
);
    import mwsg_pkg::*;

    logic [PHASE_BITS-1:0] acc_reg, acc_next;
    logic [PHASE_BITS-1:0] base;
    logic                  accept;

    assign s_tready = !hold && !q_status.full;
    assign accept   = s_tvalid && s_tready;
    // restart clears the accumulator before this tick
    assign base     = s_tdata[0] ? '0 : acc_reg;
    assign q_push   = accept;
    assign q_data   = base + phase_offset;
    assign acc_next = accept ? (base + phase_step) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== hdl/mwsg_coef.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwsg_coef
// Derives sine/triangle peaks and the rounded bias from the amplitude
// registers; the bias divide by 10000 runs as long division in 16-bit
// digits, each quotient digit found by a reciprocal multiply.
// ---------------------------------------------------------------------------
module mwsg_coef (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [mwsg_pkg::AMP_W-1:0]        amplitude,
    input  logic signed [mwsg_pkg::PCT_W-1:0] offset_percent,
    output mwsg_pkg::coef_t                   coef,
    output logic                              busy
);
    import mwsg_pkg::*;

    localparam int CntW       = $clog2(DIV_DIGITS);
    localparam int PartW      = REM_W + DIV_DIGIT_W;
    localparam int RecipProdW = PartW + RECIP_W;

    coef_state_t             state_reg, state_next;
    logic [PEAK_W-1:0]       sine_peak_reg, sine_peak_next;
    logic [PEAK_W-1:0]       tri_peak_reg, tri_peak_next;
    logic [DIVIDEND_W-1:0]   quot_reg, quot_next;
    logic [DIV_DIGIT_W-1:0]  digit_reg, digit_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [CntW-1:0]         cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;

    logic [PCT_W-1:0]        pct_mag;
    logic [PEAK_PROD_W-1:0]  sine_prod;
    logic [PEAK_PROD_W-1:0]  tri_prod;
    logic [PROD_D_W-1:0]     bias_prod;
    logic [PartW-1:0]        part;
    logic [RecipProdW-1:0]   recip_prod;
    logic [PartW-1:0]        part_rem;

    assign pct_mag    = offset_percent[PCT_W-1] ? (~unsigned'(offset_percent) + 1'b1)
                                                : unsigned'(offset_percent);
    assign sine_prod  = PEAK_PROD_W'(amplitude) * PEAK_PROD_W'(SQRT2_Q16)
                      + PEAK_PROD_W'(32768);
    assign tri_prod   = PEAK_PROD_W'(amplitude) * PEAK_PROD_W'(SQRT3_Q16)
                      + PEAK_PROD_W'(32768);
    assign bias_prod  = PROD_D_W'(amplitude) * PROD_D_W'(pct_mag) + PROD_D_W'(BIAS_ROUND);
    // partial dividend: running remainder above the next dividend digit
    assign part       = {rem_reg, quot_reg[DIVIDEND_W-1 -: DIV_DIGIT_W]};
    assign recip_prod = RecipProdW'(part) * RecipProdW'(RECIP_10000);
    assign part_rem   = part - PartW'(digit_reg) * PartW'(BIAS_DIVISOR);

    always_comb begin
        state_next     = state_reg;
        sine_peak_next = sine_peak_reg;
        tri_peak_next  = tri_peak_reg;
        quot_next      = quot_reg;
        digit_next     = digit_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        unique case (state_reg)
            COEF_IDLE: begin
                state_next = COEF_IDLE;
            end
            COEF_MUL: begin
                sine_peak_next = sine_prod[16 +: PEAK_W];
                tri_peak_next  = tri_prod[16 +: PEAK_W];
                quot_next      = DIVIDEND_W'(bias_prod);
                rem_next       = '0;
                cnt_next       = '0;
                neg_next       = offset_percent[PCT_W-1];
                state_next     = COEF_DIV;
            end
            COEF_DIV: begin
                // quotient digit of the partial dividend
                digit_next = recip_prod[RECIP_SHIFT +: DIV_DIGIT_W];
                state_next = COEF_REM;
            end
            COEF_REM: begin
                // keep the remainder, shift the quotient digit in
                rem_next  = part_rem[REM_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-DIV_DIGIT_W-1:0], digit_reg};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DIV_DIGITS - 1)) begin
                    state_next = COEF_IDLE;
                end else begin
                    state_next = COEF_DIV;
                end
            end
            default: begin
                state_next = COEF_IDLE;
            end
        endcase
        if (start) begin
            state_next = COEF_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= COEF_MUL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        sine_peak_reg <= sine_peak_next;
        tri_peak_reg  <= tri_peak_next;
        quot_reg      <= quot_next;
        digit_reg     <= digit_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        neg_reg       <= neg_next;
    end

    assign busy           = (state_reg != COEF_IDLE);
    assign coef.sine_peak = sine_peak_reg;
    assign coef.tri_peak  = tri_peak_reg;
    assign coef.bias      = neg_reg ? -signed'(quot_reg[BIAS_W-1:0])
                                    : signed'(quot_reg[BIAS_W-1:0]);

endmodule

// ===== hdl/mwsg_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mwsg_back
// Turns queued phases into samples: table lookup, peak multiply, rounding,
// bias add and saturation, then the output register.
// ---------------------------------------------------------------------------
module mwsg_back #(
    parameter int SINE_TABLE_DEPTH = mwsg_pkg::SINE_TABLE_DEPTH_DEFAULT,
    parameter int PHASE_BITS       = mwsg_pkg::PHASE_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mwsg_pkg::q_status_t            q_status,
    input  logic [PHASE_BITS-1:0]          q_data,
    output logic                           q_pop,
    input  logic [mwsg_pkg::WAVE_W-1:0]    wave_sel,
    input  logic [mwsg_pkg::AMP_W-1:0]     amplitude,
    input  mwsg_pkg::coef_t                coef,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mwsg_pkg::M_TDATA_W-1:0] m_tdata     // [31:0] sample_value, [63:32] phase_now
);
    import mwsg_pkg::*;

    localparam int QShift  = PHASE_BITS - 2;
    localparam int IdxW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int ProdW   = QShift + IdxW;
    localparam int MagW    = QShift + 1;
    localparam int MulW    = PEAK_W + MagW;
    localparam int ScaledW = PEAK_W + 1;
    localparam int SumW    = BIAS_W + 2;

    localparam logic [MagW-1:0] QuarterTurn = {1'b1, {QShift{1'b0}}};
    localparam logic [MulW-1:0] RoundTri    = MulW'(1) << (QShift - 1);
    localparam logic [MulW-1:0] RoundSine   = MulW'(1) << (TAB_W - 1);
    localparam logic signed [SumW-1:0] SatMax =
        {{(SumW - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SumW-1:0] SatMin =
        {{(SumW - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

    // quarter-wave table, entry DEPTH is the peak
    logic [TAB_W-1:0] sine_rom [SINE_TABLE_DEPTH + 1];

    for (genvar n = 0; n <= SINE_TABLE_DEPTH; n++) begin : g_rom
        assign sine_rom[n] = quarter_sine_q15((HALF_PI_Q30 * 64'(n)) / SINE_TABLE_DEPTH);
    end

    logic                  en;
    logic                  is_tri;

    logic                  s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                  m_valid_reg;
    logic [PHASE_BITS-1:0] s0_phase_reg, s1_phase_reg, s2_phase_reg, s3_phase_reg;
    logic [IdxW-1:0]       s0_idx_reg, s0_idx_next;
    logic [MagW-1:0]       s0_tri_reg, s0_tri_next, s1_tri_reg;
    logic [TAB_W-1:0]      s1_tab_reg;
    logic [MulW-1:0]       s2_prod_reg, s2_prod_next;
    logic [ScaledW-1:0]    s3_mag_reg, s3_mag_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic [1:0]            quad;
    logic [QShift-1:0]     frac;
    logic [ProdW-1:0]      pos_full;
    logic [IdxW-1:0]       pos;
    logic [MulW-1:0]       rounded;
    logic [MulW-1:0]       shifted;
    logic                  neg;
    logic signed [SumW-1:0] amp_s, bias_s, scaled_s, sum;
    logic signed [SumW-1:0] sat;

    // the whole pipe advances whenever the output register can take a word
    assign en     = !m_valid_reg || m_tready;
    assign q_pop  = en && !q_status.empty;
    assign is_tri = (wave_t'(wave_sel) == WAVE_TRIANGLE);

    // stage 0: quadrant split, table index and triangle magnitude
    always_comb begin
        quad        = q_data[PHASE_BITS-1 -: 2];
        frac        = q_data[QShift-1:0];
        pos_full    = ProdW'(frac) * ProdW'(SINE_TABLE_DEPTH);
        pos         = pos_full[QShift +: IdxW];
        s0_idx_next = quad[0] ? (IdxW'(SINE_TABLE_DEPTH) - pos) : pos;
        s0_tri_next = quad[0] ? (QuarterTurn - MagW'(frac)) : MagW'(frac);
    end

    // stage 2: one multiply, peak times magnitude
    always_comb begin
        if (is_tri) begin
            s2_prod_next = MulW'(coef.tri_peak) * MulW'(s1_tri_reg);
        end else begin
            s2_prod_next = MulW'(coef.sine_peak) * MulW'(s1_tab_reg);
        end
    end

    // stage 3: round halves up and drop the fraction
    always_comb begin
        rounded     = s2_prod_reg + (is_tri ? RoundTri : RoundSine);
        shifted     = is_tri ? (rounded >> QShift) : (rounded >> TAB_W);
        s3_mag_next = shifted[ScaledW-1:0];
    end

    // stage 4: sign, bias, saturate
    always_comb begin
        neg      = s3_phase_reg[PHASE_BITS-1];
        amp_s    = signed'(SumW'(amplitude));
        bias_s   = SumW'(coef.bias);
        scaled_s = neg ? -signed'(SumW'(s3_mag_reg)) : signed'(SumW'(s3_mag_reg));
        unique case (wave_t'(wave_sel))
            WAVE_SQUARE:   sum = (neg ? -amp_s : amp_s) + bias_s;
            WAVE_TRIANGLE: sum = scaled_s;
            WAVE_DC:       sum = amp_s + bias_s;
            default:       sum = scaled_s + bias_s;
        endcase
        if (sum > SatMax) begin
            sat = SatMax;
        end else if (sum < SatMin) begin
            sat = SatMin;
        end else begin
            sat = sum;
        end
        m_data_next = {PHASE_OUT_W'(s3_phase_reg), sat[SAMPLE_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= q_pop;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_phase_reg <= q_data;
            s0_idx_reg   <= s0_idx_next;
            s0_tri_reg   <= s0_tri_next;
            s1_phase_reg <= s0_phase_reg;
            s1_tab_reg   <= sine_rom[s0_idx_reg];
            s1_tri_reg   <= s0_tri_reg;
            s2_phase_reg <= s1_phase_reg;
            s2_prod_reg  <= s2_prod_next;
            s3_phase_reg <= s2_phase_reg;
            s3_mag_reg   <= s3_mag_next;
            m_data_reg   <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
